@@ hw/rtl/gbn_pkg.sv @@
`default_nettype none

package gbn_pkg;

	localparam int SEGMENT_BYTES = 1450;
	localparam int MAX_WINDOW    = 32;

	localparam int SEQ_W  = 22;
	localparam int WIN_W  = 6;
	localparam int CIDX_W = 2;

	// The last segment number is (file_size - 1) * RECIP_MUL >> RECIP_SHIFT. At this segment
	// length the rounded-up reciprocal is exact for every 32-bit dividend.
	localparam int          RECIP_SHIFT = 31 + $clog2(SEGMENT_BYTES);
	localparam logic [31:0] RECIP_MUL   =
		32'(((64'd1 << RECIP_SHIFT) + 64'(SEGMENT_BYTES - 1)) / 64'(SEGMENT_BYTES));

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [CIDX_W-1:0] REG_FILE_SIZE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE = 2'd1;
	localparam logic [CIDX_W-1:0] REG_ACK_TYPE    = 2'd2;

	localparam logic [31:0] FILE_SIZE_RST = 32'd1450;
	localparam logic [7:0]  ACK_TYPE_RST  = 8'h10;
	localparam logic [7:0]  TYPE_MASK     = 8'hFB;
	localparam logic [15:0] CKSUM_GOOD    = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SEQ     = 3'd1,
		ST_CKSUM   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_TYPE    = 3'd4,
		ST_WINDOW  = 3'd5,
		ST_NOT_ACK = 3'd6
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbn_if.sv @@
`default_nettype none

interface gbn_evt_if import gbn_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] ack_seq_field;
	logic [31:0] ack_number;
	logic [7:0]  ack_flags;
	logic [15:0] ack_window;
	logic [15:0] ack_checksum;

	modport source (output valid, kind, ack_seq_field, ack_number, ack_flags, ack_window,
		ack_checksum, input ready);
	modport sink (input valid, kind, ack_seq_field, ack_number, ack_flags, ack_window,
		ack_checksum, output ready);
endinterface

interface gbn_res_if import gbn_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             send_valid;
	logic [SEQ_W-1:0] send_seq;
	logic             final_segment;
	logic [2:0]       status;
	logic             transfer_done;
	logic             last_of_run;

	modport source (output valid, send_valid, send_seq, final_segment, status, transfer_done,
		last_of_run, input ready);
	modport sink (input valid, send_valid, send_seq, final_segment, status, transfer_done,
		last_of_run, output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [31:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/go_back_n_send_window.sv @@
// Go-back-N sender window. Events arrive on evt (start, ACK, timeout) and each one produces
// one or more results on res, the last marked by last_of_run; an event that sends nothing
// gives a single result with send_valid low. One event is handled at a time and evt.ready is
// low from its transfer until its last result has been loaded into the output register, so
// the next event can be taken in the cycle after that. Before it emits, a start finds the
// last segment number by a reciprocal multiplication of the file size, resets the window
// and loads it. An ACK is checked in S_CHK1 and S_CHK2; a rejected ACK then goes straight
// to its result, an accepted one slides the window and, unless it ends the transfer, loads
// it. A timeout of an open transfer loads the window first; any other timeout, or an event
// of unknown kind, goes straight to its result. After that every event emits one result per
// cycle while res.ready is high, and no event gives more than 32 results.
// Configuration writes are taken in any cycle and should only be issued while idle.
`default_nettype none

module go_back_n_send_window import gbn_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	gbn_evt_if.sink   evt,
	gbn_res_if.source res,
	gbn_cfg_if.sink   cfg
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DIV   = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_CHK1  = 9'b000001000,
		S_CHK2  = 9'b000010000,
		S_UPD   = 9'b000100000,
		S_LOAD  = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_NULL  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0]      file_size_q;
	logic [WIN_W-1:0] window_size_q;
	logic [7:0]       ack_type_q;

	// Window state.
	logic [SEQ_W-1:0] base_q;
	logic [WIN_W-1:0] in_flight_q;
	logic             done_q;
	logic             running_q;
	logic [SEQ_W-1:0] last_q;

	// Sequencer registers.
	logic [WIN_W-1:0] idx_q;
	logic             resend_q;
	status_t          status_q;
	logic [SEQ_W-1:0] quot_q;

	// Captured ACK fields.
	logic        seq_nz_q;
	logic [31:0] ack_q;
	logic [7:0]  flags_q;
	logic [15:0] win_q;
	logic [15:0] cks_q;
	logic [18:0] fold_q;

	// Output register.
	logic             res_valid_q;
	logic             send_valid_q;
	logic [SEQ_W-1:0] send_seq_q;
	logic             final_q;
	status_t          res_status_q;
	logic             res_done_q;
	logic             last_run_q;

	logic             out_free;
	logic             res_load;
	logic [WIN_W-1:0] eff_win;
	logic             evt_fire;

	// Segment count.
	logic [63:0] recip_prod;

	// Checksum and checks.
	logic [33:0]   sum_full;
	logic [16:0]   fold2;
	logic [15:0]   fold3;
	logic [16:0]   cks_sum;
	logic          cks_ok;
	logic          type_bad;
	logic [SEQ_W:0] win_end;
	logic          in_window;
	status_t       ack_status;

	// Window update and load.
	logic [WIN_W-1:0] used;
	logic [SEQ_W:0]   next_seg;
	logic [WIN_W-1:0] room;
	logic [SEQ_W:0]   avail;
	logic [WIN_W-1:0] loaded;
	logic [WIN_W-1:0] in_flight_new;
	logic [WIN_W-1:0] first_idx;

	// Emission.
	logic [SEQ_W-1:0] emit_seq;
	logic             emit_last;

	assign out_free = !res_valid_q || res.ready;
	assign res_load = ((state_q == S_EMIT) || (state_q == S_NULL)) && out_free;
	assign evt_fire = evt.valid && evt.ready;

	assign evt.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign res.valid         = res_valid_q;
	assign res.send_valid    = send_valid_q;
	assign res.send_seq      = send_seq_q;
	assign res.final_segment = final_q;
	assign res.status        = res_status_q;
	assign res.transfer_done = res_done_q;
	assign res.last_of_run   = last_run_q;

	always_comb begin
		if (window_size_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (window_size_q > WIN_W'(MAX_WINDOW)) begin
			eff_win = WIN_W'(MAX_WINDOW);
		end else begin
			eff_win = window_size_q;
		end
	end

	// The last segment is floor((file_size - 1) / SEGMENT_BYTES).
	assign recip_prod = 64'(file_size_q - 32'd1) * 64'(RECIP_MUL);

	// The ones'-complement fold settles after three passes for a sum this narrow.
	assign sum_full = 34'(ack_q) + 34'(flags_q) + 34'(win_q);
	assign fold2    = 17'(fold_q[15:0]) + 17'(fold_q[18:16]);
	assign fold3    = fold2[15:0] + 16'(fold2[16]);
	assign cks_sum  = 17'(fold3) + 17'(cks_q);
	assign cks_ok   = (cks_sum == 17'(CKSUM_GOOD));
	assign type_bad = ((flags_q & TYPE_MASK) != ack_type_q) && (flags_q != ack_type_q);
	assign win_end  = (SEQ_W+1)'(base_q) + (SEQ_W+1)'(eff_win);
	assign in_window = running_q && (ack_q >= 32'(base_q)) && ({1'b0, ack_q} < 33'(win_end));

	always_comb begin
		if (seq_nz_q) begin
			ack_status = ST_SEQ;
		end else if (!cks_ok) begin
			ack_status = ST_CKSUM;
		end else if (ack_q > file_size_q) begin
			ack_status = ST_RANGE;
		end else if (type_bad) begin
			ack_status = ST_TYPE;
		end else if (!in_window) begin
			ack_status = ST_WINDOW;
		end else begin
			ack_status = ST_OK;
		end
	end

	// The acknowledged number lies less than a window past the base, so low bits suffice.
	assign used = ack_q[WIN_W-1:0] - base_q[WIN_W-1:0] + WIN_W'(1);

	always_comb begin
		next_seg = (SEQ_W+1)'(base_q) + (SEQ_W+1)'(in_flight_q);
		room     = eff_win - in_flight_q;
		avail    = (SEQ_W+1)'(last_q) - next_seg + (SEQ_W+1)'(1);
		loaded   = '0;
		if ((in_flight_q < eff_win) && (next_seg <= (SEQ_W+1)'(last_q))) begin
			if ((SEQ_W+1)'(room) < avail) begin
				loaded = room;
			end else begin
				loaded = avail[WIN_W-1:0];
			end
		end
		in_flight_new = in_flight_q + loaded;
		first_idx     = resend_q ? '0 : in_flight_q;
	end

	assign emit_seq  = base_q + SEQ_W'(idx_q);
	assign emit_last = (idx_q + WIN_W'(1)) == in_flight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q   <= FILE_SIZE_RST;
			window_size_q <= WIN_W'(MAX_WINDOW);
			ack_type_q    <= ACK_TYPE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FILE_SIZE:   file_size_q   <= cfg.data;
				REG_WINDOW_SIZE: window_size_q <= cfg.data[WIN_W-1:0];
				REG_ACK_TYPE:    ack_type_q    <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			in_flight_q <= '0;
			done_q      <= 1'b0;
			running_q   <= 1'b0;
			last_q      <= '0;
			idx_q       <= '0;
			resend_q    <= 1'b0;
			status_q    <= ST_NOT_ACK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (evt_fire) begin
						status_q <= ST_NOT_ACK;
						resend_q <= 1'b0;
						case (evt.kind)
							KIND_START: begin
								state_q <= S_DIV;
							end
							KIND_ACK: begin
								state_q <= S_CHK1;
							end
							KIND_TIMEOUT: begin
								resend_q <= 1'b1;
								state_q  <= running_q ? S_LOAD : S_NULL;
							end
							default: begin
								state_q <= S_NULL;
							end
						endcase
					end
				end
				S_DIV: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					last_q      <= quot_q;
					base_q      <= '0;
					in_flight_q <= '0;
					done_q      <= 1'b0;
					running_q   <= 1'b1;
					state_q     <= S_LOAD;
				end
				S_CHK1: begin
					state_q <= S_CHK2;
				end
				S_CHK2: begin
					status_q <= ack_status;
					state_q  <= (ack_status == ST_OK) ? S_UPD : S_NULL;
				end
				S_UPD: begin
					base_q <= ack_q[SEQ_W-1:0] + SEQ_W'(1);
					if (ack_q == 32'(last_q)) begin
						done_q      <= 1'b1;
						running_q   <= 1'b0;
						in_flight_q <= '0;
						state_q     <= S_NULL;
					end else begin
						in_flight_q <= (in_flight_q > used) ? in_flight_q - used : '0;
						state_q     <= S_LOAD;
					end
				end
				S_LOAD: begin
					in_flight_q <= in_flight_new;
					idx_q       <= first_idx;
					state_q     <= (first_idx < in_flight_new) ? S_EMIT : S_NULL;
				end
				S_EMIT: begin
					if (out_free) begin
						idx_q <= idx_q + WIN_W'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_NULL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (evt_fire) begin
			seq_nz_q <= (evt.ack_seq_field != '0);
			ack_q    <= evt.ack_number;
			flags_q  <= evt.ack_flags;
			win_q    <= evt.ack_window;
			cks_q    <= evt.ack_checksum;
		end
		if (state_q == S_DIV) begin
			// A zero file size still counts as a single segment.
			quot_q <= (file_size_q == '0) ? '0 : recip_prod[RECIP_SHIFT +: SEQ_W];
		end
		if (state_q == S_CHK1) begin
			fold_q <= 19'(sum_full[15:0]) + 19'(sum_full[33:16]);
		end
		if (state_q == S_EMIT && out_free) begin
			send_valid_q <= 1'b1;
			send_seq_q   <= emit_seq;
			final_q      <= (emit_seq == last_q);
			res_status_q <= status_q;
			res_done_q   <= done_q;
			last_run_q   <= emit_last;
		end else if (state_q == S_NULL && out_free) begin
			send_valid_q <= 1'b0;
			send_seq_q   <= '0;
			final_q      <= 1'b0;
			res_status_q <= status_q;
			res_done_q   <= done_q;
			last_run_q   <= 1'b1;
		end
	end

	a_in_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= WIN_W'(MAX_WINDOW))
		else $error("in_flight exceeds the largest window");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (idx_q < in_flight_q))
		else $error("emit index ran past the outstanding segments");

	a_done_closed: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !running_q)
		else $error("transfer marked done while still open");

	a_final_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && final_q) |-> send_valid_q)
		else $error("final segment flag on a result that sends nothing");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |=> (res_valid_q && $stable(send_seq_q)))
		else $error("pending result was overwritten");

endmodule

`default_nettype wire
